// ===== rtl/core/grdfs_pkg.sv =====
// Shared types and constants for the graph reachability block.
package grdfs_pkg;

    // Width of a vertex number on the item channel
    localparam int FIELD_W = 7;

    // Operation codes of an input word
    localparam logic OP_ADD_EDGE = 1'b0;
    localparam logic OP_QUERY    = 1'b1;

    // Walk controller states
    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_EDGE_WR,
        S_POP,
        S_FETCH,
        S_SCAN,
        S_PUSH,
        S_DONE
    } t_state;

    // Adjacency memory port strobes
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_adj_ctl;

    // Walk stack commands
    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } t_stk_ctl;

    // Finished query toward the output register
    typedef struct packed {
        logic valid;
        logic reachable;
    } t_result;

endpackage

// ===== rtl/core/grdfs_in_if.sv =====
// Input channel: operation and two vertex numbers with valid/ready.
interface grdfs_in_if import grdfs_pkg::*;;
    logic               valid;
    logic               ready;
    logic               operation;
    logic [FIELD_W-1:0] from_vertex;
    logic [FIELD_W-1:0] to_vertex;

    modport source (output valid, output operation, output from_vertex, output to_vertex,
                    input ready);
    modport sink   (input valid, input operation, input from_vertex, input to_vertex,
                    output ready);
endinterface

// ===== rtl/core/grdfs_out_if.sv =====
// Output channel: one reachability bit per query with valid/ready.
interface grdfs_out_if;
    logic valid;
    logic ready;
    logic reachable;

    modport source (output valid, output reachable, input ready);
    modport sink   (input valid, input reachable, output ready);
endinterface

// ===== rtl/core/grdfs_adj_mem.sv =====
// Adjacency matrix memory: one row per vertex, one write and one registered read port.
module grdfs_adj_mem import grdfs_pkg::*; #(
    parameter int VERTICES = 128,
    localparam int VW = $clog2(VERTICES)
) (
    input  logic                i_clk,
    input  t_adj_ctl            i_ctl,
    input  logic [VW-1:0]       i_rd_addr,
    input  logic [VW-1:0]       i_wr_addr,
    input  logic [VERTICES-1:0] i_wr_row,
    output logic [VERTICES-1:0] o_rd_row
);

    logic [VERTICES-1:0] mem [VERTICES];
    logic [VERTICES-1:0] r_rd_row;

    // Write one row
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            mem[i_wr_addr] <= i_wr_row;
        end
    end

    // Read one row, registered: data appears in the next cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_row <= mem[i_rd_addr];
        end
    end

    assign o_rd_row = r_rd_row;

endmodule

// ===== rtl/core/grdfs_stack.sv =====
// Walk stack: vertex memory with a depth pointer, push and registered pop.
module grdfs_stack import grdfs_pkg::*; #(
    parameter int VERTICES = 128,
    localparam int VW = $clog2(VERTICES),
    localparam int DW = $clog2(VERTICES + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_stk_ctl      i_ctl,
    input  logic [VW-1:0] i_push_vertex,
    output logic [VW-1:0] o_top_vertex,
    output logic          o_empty
);

    logic [VW-1:0] mem [VERTICES];
    logic [VW-1:0] r_top_vertex;
    logic [DW-1:0] r_depth;
    logic [DW-1:0] n_depth;
    logic [DW-1:0] depth_dec;

    assign depth_dec = r_depth - DW'(1);

    // Next depth: clear wins, then push, then pop
    always_comb begin
        n_depth = r_depth;
        if (i_ctl.clear) begin
            n_depth = '0;
        end else if (i_ctl.push) begin
            n_depth = r_depth + DW'(1);
        end else if (i_ctl.pop) begin
            n_depth = depth_dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
        end else begin
            r_depth <= n_depth;
        end
    end

    // Store a pushed vertex at the current depth
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            mem[r_depth[VW-1:0]] <= i_push_vertex;
        end
    end

    // Read the top entry on pop
    always_ff @(posedge i_clk) begin
        if (i_ctl.pop) begin
            r_top_vertex <= mem[depth_dec[VW-1:0]];
        end
    end

    assign o_top_vertex = r_top_vertex;
    assign o_empty      = (r_depth == '0);

endmodule

// ===== rtl/core/grdfs_ctrl.sv =====
// Walk controller: edge insert, depth-first query sequencing and visited marks.
module grdfs_ctrl import grdfs_pkg::*; #(
    parameter int VERTICES = 128,
    localparam int VW = $clog2(VERTICES)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    grdfs_in_if.sink            i_in,
    input  logic                i_out_free,
    output t_result             o_result,
    output t_adj_ctl            o_adj_ctl,
    output logic [VW-1:0]       o_adj_rd_addr,
    output logic [VW-1:0]       o_adj_wr_addr,
    output logic [VERTICES-1:0] o_adj_wr_row,
    input  logic [VERTICES-1:0] i_adj_rd_row,
    output t_stk_ctl            o_stk_ctl,
    output logic [VW-1:0]       o_stk_push_vertex,
    input  logic [VW-1:0]       i_stk_top_vertex,
    input  logic                i_stk_empty
);

    t_state              r_state,   n_state;
    logic [VERTICES-1:0] r_visited, n_visited;
    logic [VERTICES-1:0] r_pend,    n_pend;
    logic                r_found,   n_found;
    logic [VW-1:0]       r_from,    n_from;
    logic [VW-1:0]       r_to,      n_to;
    logic [VW-1:0]       r_sweep,   n_sweep;

    logic [VW-1:0]       in_from;
    logic [VW-1:0]       in_to;
    logic                in_ok;
    logic [VERTICES-1:0] to_bit;
    logic [VERTICES-1:0] fresh;
    logic [VW-1:0]       pick;
    logic [VERTICES-1:0] pick_bit;

    // Lowest set bit of a row
    function automatic logic [VW-1:0] first_set(input logic [VERTICES-1:0] row);
        logic [VW-1:0] idx;
        idx = '0;
        for (int i = VERTICES - 1; i >= 0; i--) begin
            if (row[i]) begin
                idx = VW'(i);
            end
        end
        return idx;
    endfunction

    assign in_from  = VW'(i_in.from_vertex);
    assign in_to    = VW'(i_in.to_vertex);
    assign in_ok    = (32'(i_in.from_vertex) < VERTICES) && (32'(i_in.to_vertex) < VERTICES);
    assign to_bit   = {{(VERTICES-1){1'b0}}, 1'b1} << r_to;
    assign fresh    = i_adj_rd_row & ~r_visited;
    assign pick     = first_set(r_pend);
    assign pick_bit = {{(VERTICES-1){1'b0}}, 1'b1} << pick;

    // State and walk registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_visited <= '0;
            r_found   <= 1'b0;
            r_sweep   <= '0;
        end else begin
            r_state   <= n_state;
            r_visited <= n_visited;
            r_found   <= n_found;
            r_sweep   <= n_sweep;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        r_from <= n_from;
        r_to   <= n_to;
    end

    // Next state and port strobes
    always_comb begin
        n_state           = r_state;
        n_visited         = r_visited;
        n_pend            = r_pend;
        n_found           = r_found;
        n_from            = r_from;
        n_to              = r_to;
        n_sweep           = r_sweep;
        i_in.ready        = 1'b0;
        o_result          = '0;
        o_adj_ctl         = '0;
        o_adj_rd_addr     = r_from;
        o_adj_wr_addr     = r_from;
        o_adj_wr_row      = i_adj_rd_row | to_bit;
        o_stk_ctl         = '0;
        o_stk_push_vertex = pick;

        case (r_state)
            // Zero one adjacency row per cycle after reset
            S_INIT: begin
                o_adj_ctl.wr_en = 1'b1;
                o_adj_wr_addr   = r_sweep;
                o_adj_wr_row    = '0;
                n_sweep         = r_sweep + VW'(1);
                if (r_sweep == VW'(VERTICES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            // Take a word and start an edge insert or a walk, or go straight to the answer for a trivial query
            S_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    n_from = in_from;
                    n_to   = in_to;
                    if (i_in.operation == OP_ADD_EDGE) begin
                        if (in_ok) begin
                            o_adj_ctl.rd_en = 1'b1;
                            o_adj_rd_addr   = in_from;
                            n_state         = S_EDGE_WR;
                        end
                    end else if (i_in.from_vertex == i_in.to_vertex) begin
                        n_found = 1'b1;
                        n_state = S_DONE;
                    end else if (!in_ok) begin
                        n_found = 1'b0;
                        n_state = S_DONE;
                    end else begin
                        n_found            = 1'b0;
                        n_visited[in_from] = 1'b1;
                        o_stk_ctl.push     = 1'b1;
                        o_stk_push_vertex  = in_from;
                        n_state            = S_POP;
                    end
                end
            end
            // Write back the row with the new edge bit set
            S_EDGE_WR: begin
                o_adj_ctl.wr_en = 1'b1;
                n_state         = S_IDLE;
            end
            // Pop the next vertex, or finish when the stack runs dry
            S_POP: begin
                if (i_stk_empty) begin
                    n_state = S_DONE;
                end else begin
                    o_stk_ctl.pop = 1'b1;
                    n_state       = S_FETCH;
                end
            end
            // Fetch the popped vertex's successor row
            S_FETCH: begin
                o_adj_ctl.rd_en = 1'b1;
                o_adj_rd_addr   = i_stk_top_vertex;
                n_state         = S_SCAN;
            end
            // Check the target, mark all new successors
            S_SCAN: begin
                if (fresh[r_to]) begin
                    n_found = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_visited = r_visited | fresh;
                    n_pend    = fresh;
                    n_state   = S_PUSH;
                end
            end
            // Push pending successors, one per cycle
            S_PUSH: begin
                if (r_pend == '0) begin
                    n_state = S_POP;
                end else begin
                    o_stk_ctl.push = 1'b1;
                    n_pend         = r_pend & ~pick_bit;
                end
            end
            // Hand over the answer, drop the stack and the marks
            S_DONE: begin
                o_stk_ctl.clear = 1'b1;
                if (i_out_free) begin
                    o_result.valid     = 1'b1;
                    o_result.reachable = r_found;
                    n_visited          = '0;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/graph_reachability_dfs.sv =====
// Top level of the graph reachability block.
//
// Words arrive on i_in (valid/ready). Operation OP_ADD_EDGE sets the edge
// from_vertex -> to_vertex and returns nothing; OP_QUERY returns one word
// on o_out whose reachable bit tells whether a directed path runs from
// from_vertex to to_vertex (a vertex always reaches itself).
// An edge insert reads the adjacency row, then writes it back with the new
// edge bit set. A query that needs no walk goes from S_IDLE through S_DONE
// to the output register. For each popped vertex a walk reads the stack,
// reads the successor row, scans it and pushes each new successor; it ends
// at an empty-stack check or when the target is found. The adjacency and
// stack memories have registered reads. One word is in work at a time.
// After reset the adjacency memory is cleared one row per cycle; i_in.ready
// stays low meanwhile.
// Results sit in an output register: a stalled receiver does not block
// edge inserts, and a finished query waits there until o_out.ready.
module graph_reachability_dfs import grdfs_pkg::*; #(
    parameter int VERTICES = 128,
    localparam int VW = $clog2(VERTICES)
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    grdfs_in_if.sink     i_in,
    grdfs_out_if.source  o_out
);

    t_adj_ctl            adj_ctl;
    logic [VW-1:0]       adj_rd_addr;
    logic [VW-1:0]       adj_wr_addr;
    logic [VERTICES-1:0] adj_wr_row;
    logic [VERTICES-1:0] adj_rd_row;
    t_stk_ctl            stk_ctl;
    logic [VW-1:0]       stk_push_vertex;
    logic [VW-1:0]       stk_top_vertex;
    logic                stk_empty;
    t_result             result;
    logic                out_free;
    logic                r_out_valid;
    logic                r_reachable;

    grdfs_ctrl #(.VERTICES(VERTICES)) u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in              (i_in),
        .i_out_free        (out_free),
        .o_result          (result),
        .o_adj_ctl         (adj_ctl),
        .o_adj_rd_addr     (adj_rd_addr),
        .o_adj_wr_addr     (adj_wr_addr),
        .o_adj_wr_row      (adj_wr_row),
        .i_adj_rd_row      (adj_rd_row),
        .o_stk_ctl         (stk_ctl),
        .o_stk_push_vertex (stk_push_vertex),
        .i_stk_top_vertex  (stk_top_vertex),
        .i_stk_empty       (stk_empty)
    );

    grdfs_adj_mem #(.VERTICES(VERTICES)) u_adj_mem (
        .i_clk     (i_clk),
        .i_ctl     (adj_ctl),
        .i_rd_addr (adj_rd_addr),
        .i_wr_addr (adj_wr_addr),
        .i_wr_row  (adj_wr_row),
        .o_rd_row  (adj_rd_row)
    );

    grdfs_stack #(.VERTICES(VERTICES)) u_stack (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (stk_ctl),
        .i_push_vertex (stk_push_vertex),
        .o_top_vertex  (stk_top_vertex),
        .o_empty       (stk_empty)
    );

    // Output register frees up when empty or being taken
    assign out_free = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= result.valid || (r_out_valid && !o_out.ready);
        end
    end

    // Load the answer word
    always_ff @(posedge i_clk) begin
        if (result.valid) begin
            r_reachable <= result.reachable;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.reachable = r_reachable;

endmodule
